FILE: hdl/gcd_pkg.sv
// Shared constants, types and arithmetic helpers for the great-circle distance unit.
`timescale 1ns / 1ps
`default_nettype none
package gcd_pkg;

    localparam int CW = 34;
    typedef logic signed [CW-1:0] cq_t;

    typedef enum logic {
        CFG_RADIUS = 1'b0,
        CFG_ALT    = 1'b1
    } cfg_index_t;

    localparam cq_t FULL_TURN    = 34'sd3600000000;
    localparam cq_t NEG_FULL     = -34'sd3600000000;
    localparam cq_t HALF_TURN    = 34'sd1800000000;
    localparam cq_t NEG_HALF     = -34'sd1800000000;
    localparam cq_t QUARTER_TURN = 34'sd900000000;
    localparam cq_t NEG_QUARTER  = -34'sd900000000;
    localparam cq_t CORDIC_GAIN  = 34'sd652032874;

    // round(pi * 2^62 / 1.8e9) = 2^32 + RAD_LOW
    localparam logic [31:0] RAD_LOW = 32'd3753943213;

    localparam logic signed [32:0] Q30_ONE  = 33'sd1073741824;
    localparam logic signed [34:0] CLAMP_HI = 35'sd1073741824;
    localparam logic signed [34:0] CLAMP_LO = -35'sd1073741824;

    localparam logic [34:0] OUT_MAX      = 35'h7_FFFF_FFFF;
    localparam logic [23:0] RADIUS_RESET = 24'd6378000;

    localparam logic [29:0] ATAN_LOW [10] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149
    };

    function automatic cq_t atan_step(input int i);
        cq_t r;
        if (i < 10) begin
            r = cq_t'({4'b0000, ATAN_LOW[i]});
        end else if (i <= 30) begin
            r = cq_t'(1) <<< (30 - i);
        end else begin
            r = '0;
        end
        return r;
    endfunction

    // Q30 product with round to nearest, arithmetic shift
    function automatic logic signed [33:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = p + 64'sd536870912;
        return 34'(p >>> 30);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/gcd_isqrt.sv
// Pipelined rounded integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module gcd_isqrt #(
    parameter int W  = 62,
    parameter int SW = 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [W-1:0]   in_rad,
    input  logic [SW-1:0]  in_side,
    output logic           out_valid,
    output logic [W/2-1:0] out_root,
    output logic [SW-1:0]  out_side
);

    localparam int H  = W / 2;
    localparam int RW = H + 2;

    logic          st_v_reg    [1:H];
    logic [W-1:0]  st_rad_reg  [1:H];
    logic [H-1:0]  st_root_reg [1:H];
    logic [RW-1:0] st_rem_reg  [1:H];
    logic [SW-1:0] st_side_reg [1:H];

    logic [W-1:0]  cur_rad  [0:H-1];
    logic [H-1:0]  cur_root [0:H-1];
    logic [RW-1:0] cur_rem  [0:H-1];

    logic [W-1:0]  st_rad_next  [1:H];
    logic [H-1:0]  st_root_next [1:H];
    logic [RW-1:0] st_rem_next  [1:H];

    logic [RW-1:0] rem_s;
    logic [RW-1:0] trial;

    logic          out_v_reg;
    logic [H-1:0]  out_root_reg;
    logic [SW-1:0] out_side_reg;

    always_comb begin
        cur_rad[0]  = in_rad;
        cur_root[0] = '0;
        cur_rem[0]  = '0;
        for (int j = 1; j < H; j++) begin
            cur_rad[j]  = st_rad_reg[j];
            cur_root[j] = st_root_reg[j];
            cur_rem[j]  = st_rem_reg[j];
        end
        rem_s = '0;
        trial = '0;
        for (int j = 0; j < H; j++) begin
            rem_s = {cur_rem[j][RW-3:0], cur_rad[j][W-1 -: 2]};
            trial = {cur_root[j], 2'b01};
            if (rem_s >= trial) begin
                st_rem_next[j+1]  = rem_s - trial;
                st_root_next[j+1] = {cur_root[j][H-2:0], 1'b1};
            end else begin
                st_rem_next[j+1]  = rem_s;
                st_root_next[j+1] = {cur_root[j][H-2:0], 1'b0};
            end
            st_rad_next[j+1] = {cur_rad[j][W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 1; j <= H; j++) begin
                st_v_reg[j] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end else if (en) begin
            st_v_reg[1] <= in_valid;
            for (int j = 2; j <= H; j++) begin
                st_v_reg[j] <= st_v_reg[j-1];
            end
            out_v_reg <= st_v_reg[H];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 1; j <= H; j++) begin
                st_rad_reg[j]  <= st_rad_next[j];
                st_root_reg[j] <= st_root_next[j];
                st_rem_reg[j]  <= st_rem_next[j];
            end
            st_side_reg[1] <= in_side;
            for (int j = 2; j <= H; j++) begin
                st_side_reg[j] <= st_side_reg[j-1];
            end
            out_root_reg <= st_root_reg[H]
                          + H'(st_rem_reg[H] > RW'(st_root_reg[H]));
            out_side_reg <= st_side_reg[H];
        end
    end

    assign out_valid = out_v_reg;
    assign out_root  = out_root_reg;
    assign out_side  = out_side_reg;

endmodule
`default_nettype wire

FILE: hdl/great_circle_distance_3d_unit.sv
// Top level: pipelined great-circle distance with optional altitude combination.
//
// Input words arrive on s_tvalid/s_tready/s_tdata, one point pair per word; results
// leave on m_tvalid/m_tready/m_tdata, one distance in millimetres per word, in order.
// Radius and altitude enable are set through cfg_wr_en/cfg_index/cfg_data; the user
// must write them only while idle, the block itself does not enforce it.
// The datapath is one pipeline: angle reduction, three parallel sin/cos CORDICs,
// the cosine sum, two square roots, an atan2 CORDIC, radius scaling, squaring and a
// final square root.
// Throughput is one word per cycle unless the receiver stalls the output.
// Reset (aresetn low, synchronous) clears every valid bit and loads the register
// defaults: radius 6378000 m, altitude enabled.
// When the receiver holds m_tready low with a result waiting, the whole pipeline
// holds and s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module great_circle_distance_3d_unit
    import gcd_pkg::*;
#(
    parameter int CORDIC_STAGES = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_latitude, first_longitude, first_altitude,
    // second_latitude, second_longitude, second_altitude
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance_mm
    output logic [39:0]  m_tdata
);

    localparam int N = CORDIC_STAGES;

    logic en;
    logic [23:0] radius_reg;
    logic        alt_reg;

    logic signed [30:0] first_latitude, first_altitude, second_latitude, second_altitude;
    logic signed [31:0] first_longitude, second_longitude;
    logic signed [31:0] dz_s;

    assign first_latitude   = s_tdata[30:0];
    assign first_longitude  = s_tdata[62:31];
    assign first_altitude   = s_tdata[93:63];
    assign second_latitude  = s_tdata[124:94];
    assign second_longitude = s_tdata[156:125];
    assign second_altitude  = s_tdata[187:157];

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
            alt_reg    <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_ALT:    alt_reg    <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // angle reduction stages
    logic        in_v_reg, md_v_reg, hf_v_reg, fd_v_reg, ml_v_reg, th_v_reg;
    cq_t         in_ang_reg [3];
    cq_t         md_ang_reg [3];
    cq_t         hf_ang_reg [3];
    logic [29:0] fd_mag_reg [3];
    logic [2:0]  fd_negr_reg, fd_neg_reg, ml_negr_reg, ml_neg_reg, th_neg_reg;
    logic [29:0] ml_mag_reg [3];
    logic [61:0] ml_prod_reg [3];
    cq_t         th_z_reg [3];
    logic [31:0] in_dz_reg, md_dz_reg, hf_dz_reg, fd_dz_reg, ml_dz_reg, th_dz_reg;

    cq_t         md_ang_next [3];
    cq_t         hf_ang_next [3];
    cq_t         fold_r      [3];
    logic [29:0] fd_mag_next [3];
    logic [2:0]  fd_negr_next, fd_neg_next;
    logic [61:0] ml_prod_next [3];
    logic [63:0] th_sum       [3];
    cq_t         th_abs       [3];
    cq_t         th_z_next    [3];

    assign dz_s = 32'(first_altitude) - 32'(second_altitude);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (in_ang_reg[a] >= FULL_TURN) begin
                md_ang_next[a] = in_ang_reg[a] - FULL_TURN;
            end else if (in_ang_reg[a] <= NEG_FULL) begin
                md_ang_next[a] = in_ang_reg[a] + FULL_TURN;
            end else begin
                md_ang_next[a] = in_ang_reg[a];
            end

            if (md_ang_reg[a] >= HALF_TURN) begin
                hf_ang_next[a] = md_ang_reg[a] - FULL_TURN;
            end else if (md_ang_reg[a] < NEG_HALF) begin
                hf_ang_next[a] = md_ang_reg[a] + FULL_TURN;
            end else begin
                hf_ang_next[a] = md_ang_reg[a];
            end

            if (hf_ang_reg[a] > QUARTER_TURN) begin
                fold_r[a]      = hf_ang_reg[a] - HALF_TURN;
                fd_neg_next[a] = 1'b1;
            end else if (hf_ang_reg[a] < NEG_QUARTER) begin
                fold_r[a]      = hf_ang_reg[a] + HALF_TURN;
                fd_neg_next[a] = 1'b1;
            end else begin
                fold_r[a]      = hf_ang_reg[a];
                fd_neg_next[a] = 1'b0;
            end
            fd_negr_next[a] = fold_r[a][CW-1];
            fd_mag_next[a]  = fold_r[a][CW-1] ? 30'(-fold_r[a]) : fold_r[a][29:0];

            ml_prod_next[a] = fd_mag_reg[a] * RAD_LOW;

            th_sum[a]    = {2'b00, ml_mag_reg[a], 32'b0} + {2'b00, ml_prod_reg[a]}
                         + 64'h0000_0000_8000_0000;
            th_abs[a]    = signed'({3'b000, th_sum[a][62:32]});
            th_z_next[a] = ml_negr_reg[a] ? -th_abs[a] : th_abs[a];
        end
    end

    // rotation CORDICs, three lanes
    cq_t        rot_x_reg [1:N][3];
    cq_t        rot_y_reg [1:N][3];
    cq_t        rot_z_reg [1:N][3];
    logic       rot_v_reg   [1:N];
    logic [2:0] rot_neg_reg [1:N];
    logic [31:0] rot_dz_reg [1:N];

    cq_t rc_x [0:N-1][3];
    cq_t rc_y [0:N-1][3];
    cq_t rc_z [0:N-1][3];
    cq_t rot_x_next [1:N][3];
    cq_t rot_y_next [1:N][3];
    cq_t rot_z_next [1:N][3];
    cq_t r_dx, r_dy, r_at;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rc_x[0][a] = CORDIC_GAIN;
            rc_y[0][a] = '0;
            rc_z[0][a] = th_z_reg[a];
        end
        for (int i = 1; i < N; i++) begin
            for (int a = 0; a < 3; a++) begin
                rc_x[i][a] = rot_x_reg[i][a];
                rc_y[i][a] = rot_y_reg[i][a];
                rc_z[i][a] = rot_z_reg[i][a];
            end
        end
        r_dx = '0;
        r_dy = '0;
        r_at = '0;
        for (int i = 0; i < N; i++) begin
            for (int a = 0; a < 3; a++) begin
                r_dx = rc_y[i][a] >>> i;
                r_dy = rc_x[i][a] >>> i;
                r_at = atan_step(i);
                if (!rc_z[i][a][CW-1]) begin
                    rot_x_next[i+1][a] = rc_x[i][a] - r_dx;
                    rot_y_next[i+1][a] = rc_y[i][a] + r_dy;
                    rot_z_next[i+1][a] = rc_z[i][a] - r_at;
                end else begin
                    rot_x_next[i+1][a] = rc_x[i][a] + r_dx;
                    rot_y_next[i+1][a] = rc_y[i][a] - r_dy;
                    rot_z_next[i+1][a] = rc_z[i][a] + r_at;
                end
            end
        end
    end

    // sin/cos out, cosine sum
    logic               sc_v_reg, m1_v_reg, m2_v_reg, m3_v_reg;
    logic signed [31:0] sc_s_reg [3];
    logic signed [31:0] sc_c_reg [3];
    logic [31:0]        sc_dz_reg, m1_dz_reg, m2_dz_reg, m3_dz_reg;
    logic signed [33:0] m1_a_reg, m1_b_reg, m2_a_reg, m2_e_reg;
    logic signed [31:0] m1_cd_reg;
    logic signed [31:0] m3_c_reg;
    cq_t                sc_s_full [3];
    cq_t                sc_c_full [3];
    logic signed [34:0] c_sum;
    logic signed [31:0] m3_c_next;
    logic signed [32:0] one_minus_c, one_plus_c;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sc_s_full[a] = rot_neg_reg[N][a] ? -rot_y_reg[N][a] : rot_y_reg[N][a];
            sc_c_full[a] = rot_neg_reg[N][a] ? -rot_x_reg[N][a] : rot_x_reg[N][a];
        end
        c_sum = 35'(m2_a_reg) + 35'(m2_e_reg);
        if (c_sum > CLAMP_HI) begin
            m3_c_next = 32'(CLAMP_HI);
        end else if (c_sum < CLAMP_LO) begin
            m3_c_next = 32'(CLAMP_LO);
        end else begin
            m3_c_next = c_sum[31:0];
        end
        one_minus_c = Q30_ONE - 33'(m3_c_reg);
        one_plus_c  = Q30_ONE + 33'(m3_c_reg);
    end

    // square roots of 1 - c and 1 + c
    logic        sqa_v, sqb_v;
    logic [30:0] sqa_root, sqb_root;
    logic [15:0] sqa_side, sqb_side;

    gcd_isqrt #(.W(62), .SW(16)) u_sqrt_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m3_v_reg),
        .in_rad    ({one_minus_c[31:0], 30'b0}),
        .in_side   (m3_dz_reg[15:0]),
        .out_valid (sqa_v),
        .out_root  (sqa_root),
        .out_side  (sqa_side)
    );

    gcd_isqrt #(.W(62), .SW(16)) u_sqrt_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m3_v_reg),
        .in_rad    ({one_plus_c[31:0], 30'b0}),
        .in_side   (m3_dz_reg[31:16]),
        .out_valid (sqb_v),
        .out_root  (sqb_root),
        .out_side  (sqb_side)
    );

    // vectoring CORDIC for atan2
    cq_t         vc_x_reg [1:N];
    cq_t         vc_y_reg [1:N];
    cq_t         vc_z_reg [1:N];
    logic        vc_v_reg [1:N];
    logic [31:0] vc_dz_reg [1:N];

    cq_t vcur_x [0:N-1];
    cq_t vcur_y [0:N-1];
    cq_t vcur_z [0:N-1];
    cq_t vc_x_next [1:N];
    cq_t vc_y_next [1:N];
    cq_t vc_z_next [1:N];
    cq_t v_dx, v_dy, v_at;

    always_comb begin
        vcur_x[0] = signed'({3'b000, sqb_root});
        vcur_y[0] = signed'({3'b000, sqa_root});
        vcur_z[0] = '0;
        for (int i = 1; i < N; i++) begin
            vcur_x[i] = vc_x_reg[i];
            vcur_y[i] = vc_y_reg[i];
            vcur_z[i] = vc_z_reg[i];
        end
        v_dx = '0;
        v_dy = '0;
        v_at = '0;
        for (int i = 0; i < N; i++) begin
            v_dx = vcur_y[i] >>> i;
            v_dy = vcur_x[i] >>> i;
            v_at = atan_step(i);
            if (vcur_y[i] > 0) begin
                vc_x_next[i+1] = vcur_x[i] + v_dx;
                vc_y_next[i+1] = vcur_y[i] - v_dy;
                vc_z_next[i+1] = vcur_z[i] + v_at;
            end else begin
                vc_x_next[i+1] = vcur_x[i] - v_dx;
                vc_y_next[i+1] = vcur_y[i] + v_dy;
                vc_z_next[i+1] = vcur_z[i] - v_at;
            end
        end
    end

    // scaling, squaring
    logic        an_v_reg, tm_v_reg, sp_v_reg, sf_v_reg, p1_v_reg, p2_v_reg, p3_v_reg;
    logic [31:0] an_ang_reg, an_dz_reg, tm_dz_reg, sp_dz_reg, sf_dz_reg;
    logic [55:0] tm_t_reg;
    logic [35:0] sp_hi_reg;
    logic [9:0]  sp_lo_reg;
    logic [36:0] sf_surf_reg, p1_surf_reg, p2_surf_reg, p3_surf_reg;
    logic [33:0] p1_aa_reg;
    logic [34:0] p1_ab_reg;
    logic [35:0] p1_bb_reg;
    logic [63:0] p1_dzz_reg, p2_dzz_reg;
    logic [70:0] p2_sum_reg;
    logic [71:0] p3_rad_reg;
    logic [31:0] an_ang_next;
    logic [39:0] sp_lo_sum;

    always_comb begin
        an_ang_next = vc_z_reg[N][CW-1] ? '0 : {vc_z_reg[N][30:0], 1'b0};
        sp_lo_sum   = 40'(tm_t_reg[29:0]) * 40'd1000 + 40'h00_2000_0000;
    end

    logic        sq_v;
    logic [35:0] sq_root;
    logic [36:0] sq_surf;

    gcd_isqrt #(.W(72), .SW(37)) u_sqrt_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p3_v_reg),
        .in_rad    (p3_rad_reg),
        .in_side   (p3_surf_reg),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_side  (sq_surf)
    );

    logic        m_tvalid_reg;
    logic [34:0] m_data_reg;
    logic [34:0] m_data_next;

    always_comb begin
        if (sq_surf >= 37'(OUT_MAX)) begin
            m_data_next = OUT_MAX;
        end else if (alt_reg) begin
            m_data_next = sq_root[35] ? OUT_MAX : sq_root[34:0];
        end else begin
            m_data_next = sq_surf[34:0];
        end
    end

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, m_data_reg};

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
            md_v_reg <= 1'b0;
            hf_v_reg <= 1'b0;
            fd_v_reg <= 1'b0;
            ml_v_reg <= 1'b0;
            th_v_reg <= 1'b0;
            for (int i = 1; i <= N; i++) begin
                rot_v_reg[i] <= 1'b0;
                vc_v_reg[i]  <= 1'b0;
            end
            sc_v_reg     <= 1'b0;
            m1_v_reg     <= 1'b0;
            m2_v_reg     <= 1'b0;
            m3_v_reg     <= 1'b0;
            an_v_reg     <= 1'b0;
            tm_v_reg     <= 1'b0;
            sp_v_reg     <= 1'b0;
            sf_v_reg     <= 1'b0;
            p1_v_reg     <= 1'b0;
            p2_v_reg     <= 1'b0;
            p3_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            in_v_reg     <= s_tvalid;
            md_v_reg     <= in_v_reg;
            hf_v_reg     <= md_v_reg;
            fd_v_reg     <= hf_v_reg;
            ml_v_reg     <= fd_v_reg;
            th_v_reg     <= ml_v_reg;
            rot_v_reg[1] <= th_v_reg;
            vc_v_reg[1]  <= sqa_v && sqb_v;
            for (int i = 2; i <= N; i++) begin
                rot_v_reg[i] <= rot_v_reg[i-1];
                vc_v_reg[i]  <= vc_v_reg[i-1];
            end
            sc_v_reg     <= rot_v_reg[N];
            m1_v_reg     <= sc_v_reg;
            m2_v_reg     <= m1_v_reg;
            m3_v_reg     <= m2_v_reg;
            an_v_reg     <= vc_v_reg[N];
            tm_v_reg     <= an_v_reg;
            sp_v_reg     <= tm_v_reg;
            sf_v_reg     <= sp_v_reg;
            p1_v_reg     <= sf_v_reg;
            p2_v_reg     <= p1_v_reg;
            p3_v_reg     <= p2_v_reg;
            m_tvalid_reg <= sq_v;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            in_ang_reg[0] <= cq_t'(first_latitude);
            in_ang_reg[1] <= cq_t'(second_latitude);
            in_ang_reg[2] <= cq_t'(first_longitude) - cq_t'(second_longitude);
            in_dz_reg     <= dz_s[31] ? -dz_s : dz_s;

            md_ang_reg  <= md_ang_next;
            md_dz_reg   <= in_dz_reg;
            hf_ang_reg  <= hf_ang_next;
            hf_dz_reg   <= md_dz_reg;
            fd_mag_reg  <= fd_mag_next;
            fd_negr_reg <= fd_negr_next;
            fd_neg_reg  <= fd_neg_next;
            fd_dz_reg   <= hf_dz_reg;
            ml_mag_reg  <= fd_mag_reg;
            ml_prod_reg <= ml_prod_next;
            ml_negr_reg <= fd_negr_reg;
            ml_neg_reg  <= fd_neg_reg;
            ml_dz_reg   <= fd_dz_reg;
            th_z_reg    <= th_z_next;
            th_neg_reg  <= ml_neg_reg;
            th_dz_reg   <= ml_dz_reg;

            for (int i = 1; i <= N; i++) begin
                rot_x_reg[i] <= rot_x_next[i];
                rot_y_reg[i] <= rot_y_next[i];
                rot_z_reg[i] <= rot_z_next[i];
                vc_x_reg[i]  <= vc_x_next[i];
                vc_y_reg[i]  <= vc_y_next[i];
                vc_z_reg[i]  <= vc_z_next[i];
            end
            rot_neg_reg[1] <= th_neg_reg;
            rot_dz_reg[1]  <= th_dz_reg;
            vc_dz_reg[1]   <= {sqb_side, sqa_side};
            for (int i = 2; i <= N; i++) begin
                rot_neg_reg[i] <= rot_neg_reg[i-1];
                rot_dz_reg[i]  <= rot_dz_reg[i-1];
                vc_dz_reg[i]   <= vc_dz_reg[i-1];
            end

            for (int a = 0; a < 3; a++) begin
                sc_s_reg[a] <= sc_s_full[a][31:0];
                sc_c_reg[a] <= sc_c_full[a][31:0];
            end
            sc_dz_reg <= rot_dz_reg[N];

            m1_a_reg  <= mulq(sc_s_reg[0], sc_s_reg[1]);
            m1_b_reg  <= mulq(sc_c_reg[0], sc_c_reg[1]);
            m1_cd_reg <= sc_c_reg[2];
            m1_dz_reg <= sc_dz_reg;
            m2_a_reg  <= m1_a_reg;
            m2_e_reg  <= mulq(m1_b_reg[31:0], m1_cd_reg);
            m2_dz_reg <= m1_dz_reg;
            m3_c_reg  <= m3_c_next;
            m3_dz_reg <= m2_dz_reg;

            an_ang_reg  <= an_ang_next;
            an_dz_reg   <= vc_dz_reg[N];
            tm_t_reg    <= radius_reg * an_ang_reg;
            tm_dz_reg   <= an_dz_reg;
            sp_hi_reg   <= 36'(tm_t_reg[55:30]) * 36'd1000;
            sp_lo_reg   <= sp_lo_sum[39:30];
            sp_dz_reg   <= tm_dz_reg;
            sf_surf_reg <= 37'(sp_hi_reg) + 37'(sp_lo_reg);
            sf_dz_reg   <= sp_dz_reg;

            p1_aa_reg   <= sf_surf_reg[34:18] * sf_surf_reg[34:18];
            p1_ab_reg   <= sf_surf_reg[34:18] * sf_surf_reg[17:0];
            p1_bb_reg   <= sf_surf_reg[17:0] * sf_surf_reg[17:0];
            p1_dzz_reg  <= sf_dz_reg * sf_dz_reg;
            p1_surf_reg <= sf_surf_reg;
            p2_sum_reg  <= 71'({p1_aa_reg, p1_bb_reg}) + 71'({p1_ab_reg, 19'b0});
            p2_dzz_reg  <= p1_dzz_reg;
            p2_surf_reg <= p1_surf_reg;
            p3_rad_reg  <= 72'(p2_sum_reg) + 72'(p2_dzz_reg);
            p3_surf_reg <= p2_surf_reg;

            m_data_reg <= m_data_next;
        end
    end

endmodule
`default_nettype wire
